// ===== design/assert_macros.svh =====
// assertion macros shared by the rgb to hsl design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_HOLDS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed in %m");

// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  `ASSERT_HOLDS(label, clk, rst_n, !(cond))

`endif

// ===== design/rgbhsl_pkg.sv =====
// shared types, constants and the divider step for the rgb to hsl converter
`default_nettype none

package rgbhsl_pkg;

  // quotient bits per divider, one bit per back-end stage
  localparam int unsigned QuotW = 7;
  // remainder width, holds 100 * 255 and 255 << (QuotW - 1) with headroom
  localparam int unsigned RemW = 17;
  // divisor width, one channel
  localparam int unsigned DivW = 8;
  // shift amount width for one divider step
  localparam int unsigned ShW = $clog2(QuotW);

  localparam int unsigned QueueDepth = 4;

  localparam int unsigned HueScale = 60;
  localparam int unsigned PctScale = 100;
  localparam int unsigned LitDiv   = 510;
  localparam int unsigned FullCh   = 255;

  // lightness reciprocal of 5.1 scaled by 2^15, exact floor for max plus min up to 510
  localparam int unsigned LitRecip = 6426;
  localparam int unsigned LitShift = 15;

  localparam logic [8:0] HueBaseRed   = 9'd0;
  localparam logic [8:0] HueBaseGreen = 9'd120;
  localparam logic [8:0] HueBaseBlue  = 9'd240;
  localparam logic [8:0] HueBaseWrap  = 9'd360;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [8:0] hue;
    logic [6:0] saturation;
    logic [6:0] lightness;
  } hsl_t;

  // classified pixel handed from the front end to the back end
  typedef struct packed {
    logic [RemW-1:0] hue_num;
    logic [RemW-1:0] sat_num;
    logic [6:0]      lightness;
    logic [7:0]      hue_div;
    logic [7:0]      sat_div;
    logic [8:0]      hue_base;
    logic            hue_neg;
    logic            grey;
  } job_t;

  // one divider pipeline stage
  typedef struct packed {
    logic [RemW-1:0]  hue_rem;
    logic [RemW-1:0]  sat_rem;
    logic [QuotW-1:0] hue_quo;
    logic [QuotW-1:0] sat_quo;
    logic [6:0]       lightness;
    logic [7:0]       hue_div;
    logic [7:0]       sat_div;
    logic [8:0]       hue_base;
    logic             hue_neg;
    logic             grey;
  } stage_t;

  // restoring division step: {quotient bit, new remainder}
  function automatic logic [RemW:0] div_step(logic [RemW-1:0] rem,
                                             logic [DivW-1:0] dv,
                                             logic [ShW-1:0] sh);
    logic [RemW-1:0] shifted;
    logic [RemW:0]   res;
    shifted = RemW'(dv) << sh;
    if (rem >= shifted) begin
      res = {1'b1, rem - shifted};
    end else begin
      res = {1'b0, rem};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== design/rgbhsl_front.sv =====
// front end: max, min, chroma, hue sector, lightness and divider operands
`default_nettype none

module rgbhsl_front (
  input  wire rgbhsl_pkg::pixel_t pix_i,
  output rgbhsl_pkg::job_t        job_o
);

  logic [7:0]  mx, mn, chroma, diff;
  logic [8:0]  sum;
  logic [7:0]  sat_den;
  logic [8:0]  hue_base;
  logic        hue_neg;
  logic [21:0] lit_prod;

  // extremes, chroma and sum
  always_comb begin
    mx = pix_i.red;
    mn = pix_i.red;
    if (pix_i.green > mx) mx = pix_i.green;
    if (pix_i.blue > mx)  mx = pix_i.blue;
    if (pix_i.green < mn) mn = pix_i.green;
    if (pix_i.blue < mn)  mn = pix_i.blue;
    chroma = mx - mn;
    sum    = {1'b0, mx} + {1'b0, mn};
  end

  // saturation denominator folds around mid grey
  always_comb begin
    if (sum <= 9'(rgbhsl_pkg::FullCh)) begin
      sat_den = sum[7:0];
    end else begin
      sat_den = 8'(10'(rgbhsl_pkg::LitDiv) - {1'b0, sum});
    end
  end

  // hue sector, red wins ties over green, green over blue
  always_comb begin
    hue_base = rgbhsl_pkg::HueBaseRed;
    hue_neg  = 1'b0;
    diff     = 8'd0;
    priority if (mx == pix_i.red) begin
      if (pix_i.green >= pix_i.blue) begin
        diff = pix_i.green - pix_i.blue;
      end else begin
        diff     = pix_i.blue - pix_i.green;
        hue_neg  = 1'b1;
        hue_base = rgbhsl_pkg::HueBaseWrap;
      end
    end else if (mx == pix_i.green) begin
      hue_base = rgbhsl_pkg::HueBaseGreen;
      if (pix_i.blue >= pix_i.red) begin
        diff = pix_i.blue - pix_i.red;
      end else begin
        diff    = pix_i.red - pix_i.blue;
        hue_neg = 1'b1;
      end
    end else begin
      hue_base = rgbhsl_pkg::HueBaseBlue;
      if (pix_i.red >= pix_i.green) begin
        diff = pix_i.red - pix_i.green;
      end else begin
        diff    = pix_i.green - pix_i.red;
        hue_neg = 1'b1;
      end
    end
  end

  // scaled numerators, divisors and lightness by reciprocal multiply
  always_comb begin
    lit_prod        = 22'(sum) * 22'(rgbhsl_pkg::LitRecip);
    job_o.hue_num   = rgbhsl_pkg::RemW'(diff) * rgbhsl_pkg::RemW'(rgbhsl_pkg::HueScale);
    job_o.sat_num   = rgbhsl_pkg::RemW'(chroma) * rgbhsl_pkg::RemW'(rgbhsl_pkg::PctScale);
    job_o.lightness = 7'(lit_prod >> rgbhsl_pkg::LitShift);
    job_o.hue_div   = chroma;
    job_o.sat_div   = sat_den;
    job_o.hue_base  = hue_base;
    job_o.hue_neg   = hue_neg;
    job_o.grey      = (chroma == 8'd0);
  end

endmodule

`default_nettype wire

// ===== design/rgbhsl_queue.sv =====
// small fifo between the front end and the back end
`default_nettype none

`include "assert_macros.svh"

module rgbhsl_queue #(
  parameter int unsigned Depth = rgbhsl_pkg::QueueDepth
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   push_valid_i,
  output logic                  push_ready_o,
  input  wire rgbhsl_pkg::job_t push_data_i,
  output logic                  pop_valid_o,
  input  wire                   pop_ready_i,
  output rgbhsl_pkg::job_t      pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  rgbhsl_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `ASSERT_HOLDS(count_in_range_a, clk_i, rst_ni, count_q <= CntW'(Depth))
  `ASSERT_HOLDS(count_tracks_push_a, clk_i, rst_ni, (push && !pop) |=> (count_q == $past(count_q) + 1'b1))

endmodule

`default_nettype wire

// ===== design/rgbhsl_back.sv =====
// back end: two lockstep restoring dividers, hue fixup and output register
`default_nettype none

`include "assert_macros.svh"

module rgbhsl_back (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   job_valid_i,
  output logic                  job_ready_o,
  input  wire rgbhsl_pkg::job_t job_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output rgbhsl_pkg::hsl_t      out_data_o
);

  localparam int unsigned QW = rgbhsl_pkg::QuotW;

  rgbhsl_pkg::stage_t st_src [QW];
  rgbhsl_pkg::stage_t st_d   [QW];
  rgbhsl_pkg::stage_t st_q   [QW];
  logic [QW-1:0]      st_v_q, st_v_d;
  rgbhsl_pkg::stage_t last;
  rgbhsl_pkg::hsl_t   out_q, out_d;
  logic               out_valid_q, out_valid_d;
  logic               adv;
  logic               rem_nz;
  logic               out_in_range;

  // whole pipeline moves when the output register can take a result
  assign adv         = !out_valid_q || out_ready_i;
  assign job_ready_o = adv;

  // one quotient bit per stage, most significant bit first
  for (genvar k = 0; k < QW; k++) begin : g_stage
    if (k == 0) begin : g_first
      always_comb begin
        st_src[k]           = '0;
        st_src[k].hue_rem   = job_i.hue_num;
        st_src[k].sat_rem   = job_i.sat_num;
        st_src[k].lightness = job_i.lightness;
        st_src[k].hue_div   = job_i.hue_div;
        st_src[k].sat_div   = job_i.sat_div;
        st_src[k].hue_base  = job_i.hue_base;
        st_src[k].hue_neg   = job_i.hue_neg;
        st_src[k].grey      = job_i.grey;
      end
      assign st_v_d[k] = job_valid_i;
    end else begin : g_next
      assign st_src[k] = st_q[k-1];
      assign st_v_d[k] = st_v_q[k-1];
    end

    always_comb begin
      logic [rgbhsl_pkg::RemW:0] hs, ss;
      hs = rgbhsl_pkg::div_step(st_src[k].hue_rem, rgbhsl_pkg::DivW'(st_src[k].hue_div),
                                rgbhsl_pkg::ShW'(QW - 1 - k));
      ss = rgbhsl_pkg::div_step(st_src[k].sat_rem, rgbhsl_pkg::DivW'(st_src[k].sat_div),
                                rgbhsl_pkg::ShW'(QW - 1 - k));
      st_d[k]                  = st_src[k];
      st_d[k].hue_rem          = hs[rgbhsl_pkg::RemW-1:0];
      st_d[k].sat_rem          = ss[rgbhsl_pkg::RemW-1:0];
      st_d[k].hue_quo[QW-1-k]  = hs[rgbhsl_pkg::RemW];
      st_d[k].sat_quo[QW-1-k]  = ss[rgbhsl_pkg::RemW];
    end

    // stage payload, no reset needed
    always_ff @(posedge clk_i) begin
      if (adv) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_v_q <= '0;
    end else if (adv) begin
      st_v_q <= st_v_d;
    end
  end

  // hue from sector base, negative side rounds the quotient up; grey pixels get zero hue and saturation
  assign last   = st_q[QW-1];
  assign rem_nz = (last.hue_rem != '0);

  always_comb begin
    out_d = '0;
    if (last.grey) begin
      out_d.hue        = 9'd0;
      out_d.saturation = 7'd0;
    end else begin
      if (last.hue_neg) begin
        out_d.hue = last.hue_base - 9'(last.hue_quo) - 9'(rem_nz);
      end else begin
        out_d.hue = last.hue_base + 9'(last.hue_quo);
      end
      out_d.saturation = last.sat_quo;
    end
    out_d.lightness = last.lightness;
  end

  // output register
  assign out_valid_d = adv ? st_v_q[QW-1] : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // result fields stay within their ranges
  assign out_in_range = (out_q.hue < 9'd360) && (out_q.saturation <= 7'd100) &&
                        (out_q.lightness <= 7'd100);

  `ASSERT_HOLDS(result_in_range_a, clk_i, rst_ni, out_valid_q |-> out_in_range)
  `ASSERT_HOLDS(stall_holds_pipe_a, clk_i, rst_ni, !adv |=> $stable(st_v_q))

endmodule

`default_nettype wire

// ===== design/rgb_to_hsl_convert_top.sv =====
// top level of the rgb to hsl pixel converter
//
//   channel   direction  handshake                 payload
//   in        input      in_valid_i / in_ready_o   in_data_i  (red, green, blue)
//   out       output     out_valid_o / out_ready_i out_data_o (hue, saturation, lightness)
//
// one pixel per clock sustained while the output is not stalled
// a pixel passes through the queue, seven divider stages (one quotient bit each) and the output register
// reset clears the queue pointers and count, the stage valid bits and the output valid
// an output stall freezes the divider pipeline; the queue keeps taking pixels until full
`default_nettype none

module rgb_to_hsl_convert_top #(
  parameter int unsigned QueueDepth = rgbhsl_pkg::QueueDepth
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_ready_o,
  input  wire rgbhsl_pkg::pixel_t in_data_i,
  output logic                    out_valid_o,
  input  wire                     out_ready_i,
  output rgbhsl_pkg::hsl_t        out_data_o
);

  rgbhsl_pkg::job_t front_job, queue_job;
  logic             queue_valid, back_ready;

  // classify the incoming pixel
  rgbhsl_front u_front (
    .pix_i (in_data_i),
    .job_o (front_job)
  );

  // decouple front and back
  rgbhsl_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_data_i  (front_job),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (back_ready),
    .pop_data_o   (queue_job)
  );

  // divide and finish
  rgbhsl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (queue_valid),
    .job_ready_o (back_ready),
    .job_i       (queue_job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
